### design/ordered_key_set_table_defines.svh
// assertion macros for the ordered key set table
// used by the top level; expects signals named clk and rst_n in scope
`ifndef ORDERED_KEY_SET_TABLE_DEFINES_SVH
`define ORDERED_KEY_SET_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OKST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_key_set_table: assertion failed");

// next-cycle implication, disabled during reset
`define OKST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_key_set_table: assertion failed");

`endif

### design/okst_pkg.sv
// shared types and constants of the ordered key set table
// no dependencies; imported by the controller, the datapath and the top level
package okst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int OUT_W   = 16;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_LOOKUP         = 2'd0;
    localparam op_t OP_INSERT         = 2'd1;
    localparam op_t OP_REMOVE_SWAP    = 2'd2;
    localparam op_t OP_REMOVE_ORDERED = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic cmp_en;
        logic rd;
        logic rd_last;
        logic ptr_from_hit;
        logic wr_append;
        logic wr_swap;
        logic wr_shift;
        logic cnt_dec;
        logic set_full;
        logic res_load;
    } okst_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic hit;
        logic cmp_hit;
        logic rv;
        logic ptr_lt_used;
        logic at_full;
        logic hit_is_last;
        logic out_free;
    } okst_sts_t;

endpackage

### design/okst_ctrl.sv
// controller state machine of the ordered key set table
// depends on okst_pkg; drives the datapath through okst_cmd_t
module okst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output okst_pkg::okst_cmd_t cmd,
    input  okst_pkg::okst_sts_t sts
);
    import okst_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_OP    = 3'd2;
    localparam logic [2:0] ST_SWAP  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle; the compare works on the registered read data
                cmd.cmp_en = 1'b1;
                if (sts.cmp_hit || !sts.ptr_lt_used)
                begin
                    state_next = ST_OP;
                end
                else
                begin
                    cmd.rd = 1'b1;
                end
            end
            ST_OP:
            begin
                state_next = ST_FIN;
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (!sts.hit)
                        begin
                            if (sts.at_full)
                            begin
                                cmd.set_full = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_append = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE_SWAP:
                    begin
                        if (sts.hit)
                        begin
                            if (sts.hit_is_last)
                            begin
                                cmd.cnt_dec = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_last = 1'b1;
                                state_next  = ST_SWAP;
                            end
                        end
                    end
                    OP_REMOVE_ORDERED:
                    begin
                        if (sts.hit)
                        begin
                            cmd.ptr_from_hit = 1'b1;
                            state_next       = ST_SHIFT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_SWAP:
            begin
                cmd.wr_swap = 1'b1;
                cmd.cnt_dec = 1'b1;
                state_next  = ST_FIN;
            end
            ST_SHIFT:
            begin
                // write back the entry read last cycle one slot lower
                if (sts.rv)
                begin
                    cmd.wr_shift = 1'b1;
                end
                if (sts.ptr_lt_used)
                begin
                    cmd.rd = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/okst_datapath.sv
// datapath of the ordered key set table: key memory, scan pointer, count,
// limit register and output register; depends on okst_pkg
module okst_datapath #(
    parameter int CAPACITY = okst_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = okst_pkg::KEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [okst_pkg::LIMIT_W-1:0] cfg_data,
    input  logic [KEY_BITS-1:0]         in_key,
    input  okst_pkg::op_t               in_op,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [okst_pkg::OUT_W-1:0]  m_tdata,
    input  okst_pkg::okst_cmd_t         cmd,
    output okst_pkg::okst_sts_t         sts
);
    import okst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int PX_W  = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rdata_reg;
    logic [KEY_BITS-1:0] key_reg;
    op_t                 op_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;
    logic [CNT_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    ptr_next;
    logic [CNT_W-1:0]    used_m1;
    logic                rv_reg;
    logic [IDX_W-1:0]    rptr_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic                full_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic [KEY_BITS-1:0] wdata;
    logic                we;
    logic                cmp_hit;
    logic [CMP_W-1:0]    used_ext;
    logic [PX_W-1:0]     pos_ext;

    assign used_m1 = used_reg - CNT_W'(1);
    assign raddr   = cmd.rd_last ? used_m1[IDX_W-1:0] : ptr_reg[IDX_W-1:0];
    assign we      = cmd.wr_append || cmd.wr_swap || cmd.wr_shift;
    assign wdata   = cmd.wr_append ? key_reg : rdata_reg;

    always_comb
    begin
        if (cmd.wr_append)
        begin
            waddr = used_reg[IDX_W-1:0];
        end
        else if (cmd.wr_swap)
        begin
            waddr = pos_reg;
        end
        else
        begin
            waddr = rptr_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd || cmd.rd_last)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign cmp_hit  = rv_reg && (rdata_reg == key_reg);
    assign used_ext = CMP_W'(used_reg);
    assign pos_ext  = PX_W'(pos_reg);

    always_comb
    begin
        used_next = used_reg;
        if (cmd.wr_append)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            used_next = used_m1;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_from_hit)
        begin
            ptr_next = CNT_W'(pos_reg) + CNT_W'(1);
        end
        else if (cmd.rd)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_key;
            op_reg  <= in_op;
        end
        if (cmd.res_load)
        begin
            m_tdata_reg <= {1'b0, used_ext[COUNT_W-1:0], full_reg,
                            pos_ext[POS_W-1:0], hit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            ptr_reg      <= '0;
            rv_reg       <= 1'b0;
            rptr_reg     <= '0;
            hit_reg      <= 1'b0;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            limit_reg    <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            ptr_reg  <= ptr_next;
            rv_reg   <= cmd.rd || cmd.rd_last;
            rptr_reg <= raddr;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                pos_reg  <= '0;
                full_reg <= 1'b0;
            end
            else
            begin
                if (cmd.cmp_en && cmp_hit)
                begin
                    hit_reg <= 1'b1;
                    pos_reg <= rptr_reg;
                end
                else if (cmd.wr_append)
                begin
                    pos_reg <= used_reg[IDX_W-1:0];
                end
                if (cmd.set_full)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.res_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.op          = op_reg;
    assign sts.hit         = hit_reg;
    assign sts.cmp_hit     = cmp_hit;
    assign sts.rv          = rv_reg;
    assign sts.ptr_lt_used = (ptr_reg < used_reg);
    // limit above the store size acts as the store size
    assign sts.at_full     = (used_ext >= CMP_W'(CAPACITY)) ||
                             (used_ext >= CMP_W'(limit_reg));
    assign sts.hit_is_last = ((CNT_W'(pos_reg) + CNT_W'(1)) == used_reg);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### design/ordered_key_set_table.sv
// Ordered key set table. Holds up to CAPACITY distinct keys densely in
// a single-port-write, single-port-read memory; an insert appends, an ordered
// remove keeps the order and a swap remove moves the last key into the gap.
// Each request (op in s_tuser, key in s_tdata) gives one result. The controller
// handles one request at a time; the memory read port sets the pace, one stored
// key per cycle. A swap remove of a key other than the last adds a swap step,
// and an ordered remove shifts every later key down one slot. A new request is
// taken while the previous result still waits on the output register.
// The key store has no reset; only entries below the count are ever read.
`include "ordered_key_set_table_defines.svh"

module ordered_key_set_table #(
    parameter  int CAPACITY = okst_pkg::CAPACITY_DEF,
    parameter  int KEY_BITS = okst_pkg::KEY_BITS_DEF,
    localparam int TDATA_W  = ((KEY_BITS + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [okst_pkg::LIMIT_W-1:0] cfg_data,   // capacity_limit
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [TDATA_W-1:0]           s_tdata,    // key, zero pad
    input  logic [okst_pkg::OP_W-1:0]    s_tuser,    // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // found, position[5:0], full_res, entry_count[6:0], zero pad
    output logic [okst_pkg::OUT_W-1:0]   m_tdata
);
    import okst_pkg::*;

    okst_cmd_t cmd;
    okst_sts_t sts;

    assign cfg_ready = 1'b1;

    okst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    okst_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_op     (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one request in flight at a time
    `OKST_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // append only below the limit
    `OKST_ASSERT_IMP(a_append_not_full, cmd.wr_append, !sts.at_full)
    // the count drops only for a key that was found
    `OKST_ASSERT_IMP(a_dec_needs_hit, cmd.cnt_dec, sts.hit)
    // a waiting result is never overwritten
    `OKST_ASSERT_IMP(a_result_slot_free, cmd.res_load, !m_tvalid || m_tready)

endmodule
